// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define FEM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define FEM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/fem_pkg.sv
// Shared types and constants of the sampled edge frequency meter.
`default_nettype none
package fem_pkg;

  localparam int ADC_BITS = 12;

  localparam int SAMPLE_W = 12;
  localparam int COUNT_W  = 16;
  localparam int TIME_W   = 32;
  localparam int FREQ_W   = 16;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Level mask: only the low ADC_BITS bits of a sample are used.
  localparam logic [SAMPLE_W-1:0] LEVEL_MASK =
    (ADC_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}} : SAMPLE_W'((1 << ADC_BITS) - 1);

  localparam logic [SAMPLE_W-1:0] THRESH_RESET = SAMPLE_W'(1000);
  localparam logic [COUNT_W-1:0]  WLEN_RESET   = COUNT_W'(1000);

  // Scaled numerator 1000 * (edges - 1) fits in 26 bits.
  localparam int FREQ_SCALE = 1000;
  localparam int NUM_W      = 26;
  localparam int DIV_CNT_W  = $clog2(NUM_W);

  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = CFG_IDX_W'(1);

  localparam logic [STATUS_W-1:0] STATUS_OK        = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] STATUS_FEW_EDGES = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] STATUS_ZERO_SPAN = STATUS_W'(2);

  // One finished window, handed from the edge front end to the divider.
  typedef struct packed {
    logic [COUNT_W-1:0] edges;
    logic [TIME_W-1:0]  span;
  } fem_job_t;

endpackage
`default_nettype wire

// File: hw/rtl/fem_front.sv
// Front end: config registers, level hold, edge detection and window counting.
`default_nettype none
module fem_front (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [fem_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fem_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             take,
  input  wire logic [fem_pkg::SAMPLE_W-1:0]     sample,
  input  wire logic                             sample_valid,
  input  wire logic [fem_pkg::TIME_W-1:0]       time_ms,
  output logic                                  job_push,
  output fem_pkg::fem_job_t                     job
);

  logic [fem_pkg::SAMPLE_W-1:0] thresh_r;
  logic [fem_pkg::COUNT_W-1:0]  wlen_r;
  logic [fem_pkg::SAMPLE_W-1:0] held_r, held_nxt;
  logic [fem_pkg::COUNT_W-1:0]  scnt_r, scnt_nxt;
  logic [fem_pkg::COUNT_W-1:0]  ecnt_r, ecnt_nxt;
  logic [fem_pkg::TIME_W-1:0]   first_r, first_nxt;
  logic [fem_pkg::TIME_W-1:0]   last_r, last_nxt;
  logic [fem_pkg::SAMPLE_W-1:0] level;
  logic                         rise;
  logic                         win_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= fem_pkg::THRESH_RESET;
      wlen_r   <= fem_pkg::WLEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fem_pkg::REG_EDGE_THRESHOLD: thresh_r <= cfg_data[fem_pkg::SAMPLE_W-1:0];
        fem_pkg::REG_WINDOW_LENGTH:  wlen_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    level = sample_valid ? (sample & fem_pkg::LEVEL_MASK) : held_r;
    rise  = (level > thresh_r) && (held_r <= thresh_r);

    ecnt_nxt  = ecnt_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    if (rise) begin
      if (ecnt_r == '0) first_nxt = time_ms;
      last_nxt = time_ms;
      if (ecnt_r != '1) ecnt_nxt = ecnt_r + 1'b1;
    end
    scnt_nxt = scnt_r + 1'b1;
    // Counter wrap or reaching the window length closes the window.
    win_end  = (scnt_nxt == '0) || (scnt_nxt >= wlen_r);
    held_nxt = level;

    job.edges = ecnt_nxt;
    job.span  = last_nxt - first_nxt;
    job_push  = take && win_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= '0;
      scnt_r  <= '0;
      ecnt_r  <= '0;
      first_r <= '0;
      last_r  <= '0;
    end else if (take) begin
      if (win_end) begin
        held_r  <= '0;
        scnt_r  <= '0;
        ecnt_r  <= '0;
        first_r <= '0;
        last_r  <= '0;
      end else begin
        held_r  <= held_nxt;
        scnt_r  <= scnt_nxt;
        ecnt_r  <= ecnt_nxt;
        first_r <= first_nxt;
        last_r  <= last_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/fem_queue.sv
// Two-entry queue of finished windows between front end and divider.
`default_nettype none
module fem_queue (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire fem_pkg::fem_job_t push_job,
  input  wire logic        pop,
  output fem_pkg::fem_job_t head_job,
  output logic             empty,
  output logic             full
);

  fem_pkg::fem_job_t slot_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] fill_r;

  assign empty    = (fill_r == 2'd0);
  assign full     = (fill_r == 2'd2);
  assign head_job = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) slot_r[wptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (push && !full) wptr_r <= ~wptr_r;
      if (pop && !empty) rptr_r <= ~rptr_r;
      case ({push && !full, pop && !empty})
        2'b10:   fill_r <= fill_r + 2'd1;
        2'b01:   fill_r <= fill_r - 2'd1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/fem_back.sv
// Back end: status check, scaled numerator, bit-serial divide, result register.
`default_nettype none
module fem_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          job_avail,
  input  wire fem_pkg::fem_job_t             job,
  output logic                               job_pop,
  input  wire logic                          res_pop,
  output logic                               res_valid,
  output logic [fem_pkg::FREQ_W-1:0]         res_freq,
  output logic [fem_pkg::STATUS_W-1:0]       res_status
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                      state_r;
  logic [fem_pkg::NUM_W-1:0]       num_r;   // numerator in, quotient out
  logic [fem_pkg::TIME_W-1:0]      den_r;
  logic [fem_pkg::TIME_W-1:0]      rem_r;
  logic [fem_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic [fem_pkg::STATUS_W-1:0]    stat_r;
  logic                            valid_r;
  logic [fem_pkg::FREQ_W-1:0]      freq_r;
  logic [fem_pkg::STATUS_W-1:0]    ostat_r;
  logic [fem_pkg::TIME_W:0]        trial;
  logic                            qbit;
  logic [fem_pkg::NUM_W-1:0]       product;
  logic                            slot_free;
  logic [fem_pkg::FREQ_W-1:0]      sat_freq;

  assign job_pop   = (state_r == ST_IDLE) && job_avail;
  assign slot_free = !valid_r || res_pop;
  assign product   = fem_pkg::NUM_W'(job.edges - 1'b1) *
                     fem_pkg::NUM_W'(fem_pkg::FREQ_SCALE);
  assign trial     = {rem_r, num_r[fem_pkg::NUM_W-1]};
  assign qbit      = (trial >= {1'b0, den_r});
  assign sat_freq  = (num_r > fem_pkg::NUM_W'({fem_pkg::FREQ_W{1'b1}})) ?
                     {fem_pkg::FREQ_W{1'b1}} : num_r[fem_pkg::FREQ_W-1:0];

  assign res_valid  = valid_r;
  assign res_freq   = freq_r;
  assign res_status = ostat_r;

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        rem_r <= '0;
        den_r <= job.span;
        cnt_r <= fem_pkg::DIV_CNT_W'(fem_pkg::NUM_W - 1);
        if (job.edges < fem_pkg::COUNT_W'(2)) begin
          stat_r <= fem_pkg::STATUS_FEW_EDGES;
          num_r  <= '0;
        end else if (job.span == '0) begin
          stat_r <= fem_pkg::STATUS_ZERO_SPAN;
          num_r  <= '0;
        end else begin
          stat_r <= fem_pkg::STATUS_OK;
          num_r  <= product;
        end
      end
      ST_DIV: begin
        rem_r <= qbit ? fem_pkg::TIME_W'(trial - {1'b0, den_r})
                      : trial[fem_pkg::TIME_W-1:0];
        num_r <= {num_r[fem_pkg::NUM_W-2:0], qbit};
        cnt_r <= cnt_r - 1'b1;
      end
      default: ;
    endcase
    if (state_r == ST_DONE && slot_free) begin
      freq_r  <= sat_freq;
      ostat_r <= stat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (job_avail) begin
            if (job.edges < fem_pkg::COUNT_W'(2) || job.span == '0)
              state_r <= ST_DONE;
            else
              state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (cnt_r == '0) state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (slot_free) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
      if (state_r == ST_DONE && slot_free) valid_r <= 1'b1;
      else if (res_pop) valid_r <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/sampled_edge_frequency_meter_unit.sv
// Top level of the sampled edge frequency meter.
//
// Input queue side: push a sample (in_sample, in_sample_valid, in_time_ms)
// whenever in_full is low; one transfer per cycle is sustained while the
// window queue has room. An invalid sample repeats the held level.
// Every window_length samples close a window; the edge count and span of
// that window go into a two-entry queue toward the divider.
// Result queue side: while out_empty is low, out_frequency_hz/out_status
// hold the oldest result; out_pop takes it. Results come only at window ends.
// A window with fewer than two rising crossings or zero span skips the divider and
// goes straight to the result register; any other window runs through the
// 26-step bit-serial divider (one quotient bit per cycle).
// A stalled receiver holds the result register; the divider then waits,
// the window queue fills and in_full rises once both entries are taken.
// Config port: cfg_ready is always high; index 0 is the edge threshold,
// index 1 the window length; other indexes are ignored. Write only idle.
// Reset (synchronous, rst_n low) restores threshold 1000, window 1000,
// clears the window state and empties both queues.
`default_nettype none
module sampled_edge_frequency_meter_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_push,
  output logic                                 in_full,
  input  wire logic [fem_pkg::SAMPLE_W-1:0]    in_sample,
  input  wire logic                            in_sample_valid,
  input  wire logic [fem_pkg::TIME_W-1:0]      in_time_ms,
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output logic [fem_pkg::FREQ_W-1:0]           out_frequency_hz,
  output logic [fem_pkg::STATUS_W-1:0]         out_status,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [fem_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fem_pkg::CFG_DATA_W-1:0]  cfg_data
);

  fem_pkg::fem_job_t push_job, head_job;
  logic job_push, job_pop, q_empty, q_full;
  logic res_valid;
  logic take;

  // The front end stalls whenever the window queue is full.
  assign in_full   = q_full;
  assign take      = in_push && !q_full;
  assign cfg_ready = 1'b1;
  assign out_empty = !res_valid;

  fem_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .take         (take),
    .sample       (in_sample),
    .sample_valid (in_sample_valid),
    .time_ms      (in_time_ms),
    .job_push     (job_push),
    .job          (push_job)
  );

  fem_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .pop      (job_pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  fem_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_avail  (!q_empty),
    .job        (head_job),
    .job_pop    (job_pop),
    .res_pop    (out_pop),
    .res_valid  (res_valid),
    .res_freq   (out_frequency_hz),
    .res_status (out_status)
  );

endmodule
`default_nettype wire

// File: hw/rtl/fem_checker.sv
// Port-level checks of the frequency meter, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module fem_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_empty,
  input wire logic                            out_pop,
  input wire logic [fem_pkg::FREQ_W-1:0]      out_frequency_hz,
  input wire logic [fem_pkg::STATUS_W-1:0]    out_status
);

  `FEM_ASSERT_ALWAYS(a_empty_after_reset, !rst_n |=> out_empty,
    "result queue not empty after reset")

  `FEM_ASSERT(a_result_held, (!out_empty && !out_pop) |=>
    (!out_empty && $stable(out_frequency_hz) && $stable(out_status)),
    "waiting result changed")

  `FEM_ASSERT(a_status_code, !out_empty |->
    (out_status == fem_pkg::STATUS_OK || out_status == fem_pkg::STATUS_FEW_EDGES ||
     out_status == fem_pkg::STATUS_ZERO_SPAN), "bad status code")

  `FEM_ASSERT(a_fail_zero_freq, (!out_empty && out_status != fem_pkg::STATUS_OK) |->
    (out_frequency_hz == '0), "nonzero frequency with error status")

endmodule

bind sampled_edge_frequency_meter_unit fem_checker u_fem_checker (.*);
`default_nettype wire

// File: tb/fem_window_check_pkg.sv
`timescale 1ns / 1ps
// Window frequency predictor and result scoreboard for the frequency meter testbench.
package fem_window_check_pkg;
  import fem_pkg::*;

  typedef struct {
    logic [FREQ_W-1:0]   freq;
    logic [STATUS_W-1:0] status;
  } freq_reading_t;

  class window_frequency_tracker;
    logic [SAMPLE_W-1:0] threshold;
    logic [COUNT_W-1:0]  window_len;
    logic [SAMPLE_W-1:0] held_level;
    logic [COUNT_W-1:0]  samples_taken;
    logic [COUNT_W-1:0]  edges_seen;
    logic [TIME_W-1:0]   first_edge_tick;
    logic [TIME_W-1:0]   last_edge_tick;
    freq_reading_t       pending_readings[$];
    int unsigned         errors;

    function new();
      threshold  = THRESH_RESET;
      window_len = WLEN_RESET;
      errors     = 0;
      clear_window();
    endfunction

    function void clear_window();
      held_level      = '0;
      samples_taken   = '0;
      edges_seen      = '0;
      first_edge_tick = '0;
      last_edge_tick  = '0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_EDGE_THRESHOLD: threshold  = val[SAMPLE_W-1:0];
        REG_WINDOW_LENGTH:  window_len = val[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    // One accepted sample; queues a reading when it closes the window.
    function void take_sample(logic [SAMPLE_W-1:0] smp, logic ok, logic [TIME_W-1:0] tick);
      logic [SAMPLE_W-1:0] prior;
      logic [SAMPLE_W-1:0] lvl;
      logic [TIME_W-1:0]   span;
      logic [63:0]         quotient;
      freq_reading_t       reading;
      prior = held_level;
      lvl   = ok ? (smp & LEVEL_MASK) : prior;
      held_level = lvl;
      if (lvl > threshold && prior <= threshold) begin
        if (edges_seen == '0)
          first_edge_tick = tick;
        last_edge_tick = tick;
        if (edges_seen != '1)
          edges_seen = edges_seen + 1'b1;
      end
      samples_taken = samples_taken + 1'b1;
      if (samples_taken != '0 && samples_taken < window_len)
        return;
      span = last_edge_tick - first_edge_tick;
      reading.freq = '0;
      if (edges_seen < 2) begin
        reading.status = STATUS_FEW_EDGES;
      end else if (span == '0) begin
        reading.status = STATUS_ZERO_SPAN;
      end else begin
        quotient = (64'(FREQ_SCALE) * 64'(edges_seen - 1'b1)) / 64'(span);
        reading.freq   = (quotient > 64'hFFFF) ? '1 : quotient[FREQ_W-1:0];
        reading.status = STATUS_OK;
      end
      pending_readings.push_back(reading);
      clear_window();
    endfunction

    function void compare_result(logic [FREQ_W-1:0] freq, logic [STATUS_W-1:0] status);
      freq_reading_t want;
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected result, frequency %0d status %0d", $time, freq, status);
        errors++;
        return;
      end
      want = pending_readings.pop_front();
      if (freq !== want.freq) begin
        $display("%0t: frequency expected %0d actual %0d", $time, want.freq, freq);
        errors++;
      end
      if (status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, status);
        errors++;
      end
    endfunction
  endclass

endpackage

// File: tb/sampled_edge_frequency_meter_unit_test.sv
`timescale 1ns / 1ps
// Top-level testbench of the sampled edge frequency meter.
module sampled_edge_frequency_meter_unit_test;
  import fem_pkg::*;
  import fem_window_check_pkg::*;

  localparam int CLK_HIGH_NS   = 6;
  localparam int CLK_LOW_NS    = 6;
  localparam int RESET_CYCLES  = 7;
  // Lets the divider finish after the closing sample, with some margin.
  localparam int SETTLE_CYCLES = 40;
  // Cycles without any transfer before the run is declared hung.
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 650;
  localparam int IDLE_PERCENT  = 35;
  localparam int VALID_PERCENT = 85;

  // Index the block ignores; used to toggle the upper index bit.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

  // How the timestamps of a window are laid out.
  typedef enum logic [2:0] {
    TICKS_RISING,    // random forward steps
    TICKS_FROZEN,    // every sample on the same tick -> zero span
    TICKS_PACKED,    // dense edges, first on one tick, rest on the next -> span of one tick
    TICKS_WRAPPING,  // starts just below 2^32 and can wrap
    TICKS_NOISE      // unrelated random ticks
  } tick_pattern_t;

  logic                  clk             = 1'b0;
  logic                  rst_n           = 1'b0;
  logic                  in_push         = 1'b0;
  logic                  in_full;
  logic [SAMPLE_W-1:0]   in_sample       = '0;
  logic                  in_sample_valid = 1'b0;
  logic [TIME_W-1:0]     in_time_ms      = '0;
  logic                  out_empty;
  logic                  out_pop         = 1'b0;
  logic [FREQ_W-1:0]     out_frequency_hz;
  logic [STATUS_W-1:0]   out_status;
  logic                  cfg_valid       = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index       = '0;
  logic [CFG_DATA_W-1:0] cfg_data        = '0;

  window_frequency_tracker tracker;
  bit                      steady      = 1'b0;  // no idling on either side while set
  int unsigned             items_sent  = 0;
  int unsigned             idle_cycles = 0;

  sampled_edge_frequency_meter_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_sample        (in_sample),
    .in_sample_valid  (in_sample_valid),
    .in_time_ms       (in_time_ms),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_frequency_hz (out_frequency_hz),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #(CLK_HIGH_NS) clk = 1'b1;
    #(CLK_LOW_NS) clk = 1'b0;
  end

  // Receiver: pops at random, or every cycle during the steady stretch.
  always @(posedge clk) begin
    if (!rst_n)
      out_pop <= 1'b0;
    else
      out_pop <= steady || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Result transfers are checked on pre-edge values, so no race with the DUT.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty)
      tracker.compare_result(out_frequency_hz, out_status);
  end

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Push one sample; idles at random first. in_push stays high between
  // back-to-back transfers so it gets only one assignment per step.
  task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input logic ok,
                             input logic [TIME_W-1:0] tick);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push         <= 1'b1;
    in_sample       <= smp;
    in_sample_valid <= ok;
    in_time_ms      <= tick;
    do @(posedge clk); while (in_full);
    tracker.take_sample(smp, ok, tick);
    items_sent++;
  endtask

  // cfg_valid is left high so consecutive writes need no re-raise;
  // the caller drops it after the last write.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_register(idx, val);
  endtask

  task automatic configure(input logic [SAMPLE_W-1:0] thr, input logic [COUNT_W-1:0] wlen);
    write_register(REG_EDGE_THRESHOLD, CFG_DATA_W'(thr));
    write_register(REG_WINDOW_LENGTH, wlen);
    cfg_valid <= 1'b0;
  endtask

  // Hold the sender until every pending reading has popped, then let the
  // divider run out before anything else happens.
  task automatic drain_results();
    in_push <= 1'b0;
    while (tracker.pending_readings.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One whole window at the current settings. Levels are picked on either
  // side of the threshold (with the boundary values mixed in); invalid
  // samples carry junk that must be ignored.
  task automatic run_window(input tick_pattern_t pattern);
    int unsigned         count;
    logic [TIME_W-1:0]   base;
    logic [TIME_W-1:0]   tick;
    logic [SAMPLE_W-1:0] lvl;
    logic                ok;
    bit                  rise;
    count = (tracker.window_len < 2) ? 1 : 32'(tracker.window_len);
    base  = (pattern == TICKS_WRAPPING) ? ~TIME_W'($urandom_range(40)) : $urandom();
    tick  = base;
    for (int i = 0; i < count; i++) begin
      rise = (pattern == TICKS_PACKED) ? (i % 2 == 0) : ($urandom_range(1) != 0);
      ok   = (pattern == TICKS_PACKED) || ($urandom_range(99) < VALID_PERCENT);
      if (!ok)
        lvl = SAMPLE_W'($urandom());
      else if (rise && tracker.threshold != '1)
        lvl = ($urandom_range(3) == 0) ? tracker.threshold + 1'b1
              : SAMPLE_W'($urandom_range(4095, tracker.threshold + 1));
      else if (rise)
        lvl = '1;
      else
        lvl = ($urandom_range(3) == 0) ? tracker.threshold
              : SAMPLE_W'($urandom_range(tracker.threshold, 0));
      case (pattern)
        TICKS_RISING:   tick = tick + $urandom_range(60, 1);
        TICKS_FROZEN:   tick = base;
        TICKS_PACKED:   tick = (i == 0) ? base : base + 1;
        TICKS_WRAPPING: tick = tick + $urandom_range(3);
        default:        tick = $urandom();
      endcase
      push_sample(lvl, ok, tick);
    end
  endtask

  initial begin
    int unsigned         random_start;
    int unsigned         phase;
    int unsigned         pick;
    int unsigned         eff_len;
    int unsigned         windows;
    logic [SAMPLE_W-1:0] thr;
    logic [COUNT_W-1:0]  wlen;
    tick_pattern_t       pattern;

    tracker = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Threshold keeps its reset value (1000) at first.
    write_register(REG_WINDOW_LENGTH, 16'd4);
    cfg_valid <= 1'b0;
    // plain window, previous level is 0 at window start: edges at 20 and 40
    push_sample(12'd0, 1'b1, 32'd10);
    push_sample(12'd4095, 1'b1, 32'd20);
    push_sample(12'd500, 1'b1, 32'd30);
    push_sample(12'd1001, 1'b1, 32'd40);
    // too few edges; exactly-at-threshold is low; invalid repeats held level
    push_sample(12'd1000, 1'b1, 32'd5);
    push_sample(12'd1001, 1'b1, 32'd6);
    push_sample(12'd0, 1'b0, 32'd7);
    push_sample(12'd4095, 1'b1, 32'd8);
    // two rising crossings on the same tick -> zero span
    push_sample(12'd2000, 1'b1, 32'd77);
    push_sample(12'd0, 1'b1, 32'd77);
    push_sample(12'd2000, 1'b1, 32'd77);
    push_sample(12'd5, 1'b1, 32'd77);
    // tick wraps between first and last edge
    push_sample(12'd3000, 1'b1, 32'hFFFF_FFFE);
    push_sample(12'd0, 1'b1, 32'hFFFF_FFFF);
    push_sample(12'd3000, 1'b1, 32'd3);
    push_sample(12'd0, 1'b1, 32'd4);
    // invalid first sample of a window repeats level 0, not the old level
    push_sample(12'd4095, 1'b0, 32'd1);
    push_sample(12'd4095, 1'b1, 32'd2);
    push_sample(12'd0, 1'b1, 32'd3);
    push_sample(12'd4095, 1'b1, 32'd4);
    drain_results();

    // short windows: one sample each, lowest threshold
    configure(12'd0, 16'd1);
    push_sample(12'd0, 1'b1, 32'd0);
    push_sample(12'd1, 1'b1, 32'd1);
    drain_results();
    configure(12'd0, 16'd0);
    push_sample(12'hFFF, 1'b1, 32'hFFFF_FFFF);
    push_sample(12'hFFF, 1'b0, 32'd0);
    drain_results();

    // highest threshold: nothing can count as high; spare index is ignored
    write_register(REG_SPARE, 16'hFFFF);
    configure(12'hFFF, 16'd2);
    push_sample(12'hFFF, 1'b1, 32'd5);
    push_sample(12'hFFF, 1'b1, 32'd6);
    drain_results();

    // 70 rising crossings over a span of one tick -> saturated frequency
    configure(12'd0, 16'd140);
    run_window(TICKS_PACKED);

    // Random part: phases of whole windows at fresh settings. One phase
    // runs with no idling on either side.
    random_start = items_sent;
    phase        = 0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      drain_results();
      case ($urandom_range(5))
        0:       thr = '0;
        1:       thr = '1;
        default: thr = SAMPLE_W'($urandom());
      endcase
      pick = $urandom_range(99);
      if (pick < 10)
        wlen = COUNT_W'($urandom_range(1));
      else if (pick < 80)
        wlen = COUNT_W'($urandom_range(16, 2));
      else
        wlen = COUNT_W'($urandom_range(200, 40));
      configure(thr, wlen);
      steady  = (phase == 2);
      eff_len = (wlen < 2) ? 1 : 32'(wlen);
      windows = 1 + 60 / eff_len;
      for (int w = 0; w < windows; w++) begin
        pick = $urandom_range(99);
        if (pick < 40)
          pattern = TICKS_RISING;
        else if (pick < 55)
          pattern = TICKS_FROZEN;
        else if (pick < 70)
          pattern = TICKS_PACKED;
        else if (pick < 85)
          pattern = TICKS_WRAPPING;
        else
          pattern = TICKS_NOISE;
        run_window(pattern);
      end
      steady = 1'b0;
      phase++;
    end

    drain_results();
    if (tracker.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
